### rtl/moe_router_softmax_topk_macros.svh
// assertion macros for the router gate
`ifndef MOE_ROUTER_SOFTMAX_TOPK_MACROS_SVH
`define MOE_ROUTER_SOFTMAX_TOPK_MACROS_SVH
`ifndef SYNTHESIS
`define MRST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mrst check failed");
`define MRST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mrst check failed");
`else
`define MRST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MRST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/mrst_pkg.sv
`timescale 1ns / 1ps
package mrst_pkg;
	localparam int LOGIT_W = 16;
	localparam int ID_W = 8;
	localparam int WGT_W = 17;
	localparam int K_W = 5;
	localparam logic [K_W-1:0] K_RESET = 5'd8;
	localparam logic signed [LOGIT_W-1:0] LOGIT_MIN = 16'sh8000;
	localparam logic [15:0] LOG2E_Q15 = 16'd47274;
	localparam int FRAC_BITS = 16;
	localparam int BIT_IDX_W = 4;
	localparam int V_W = 31;
	localparam int T_W = 32;
	localparam int N_MAX = 40;
	localparam logic [V_W-1:0] ONE_Q30 = 31'h4000_0000;
	localparam int Q_STEPS = 17;

	typedef enum logic [2:0] {
		S_LOAD,
		S_EXP,
		S_EXP_WAIT,
		S_DIV,
		S_DIV_WAIT,
		S_OUT
	} ctl_state_t;

	typedef enum logic [1:0] {
		E_IDLE,
		E_MUL,
		E_POW,
		E_SCALE
	} exp_state_t;

	typedef enum logic [1:0] {
		D_IDLE,
		D_RUN,
		D_DONE
	} div_state_t;

	typedef struct packed {
		logic start;
		logic [LOGIT_W-1:0] diff;
	} exp_req_t;

	typedef struct packed {
		logic done;
		logic [V_W-1:0] e;
	} exp_rsp_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] bt;
		x = x_in;
		r = '0;
		bt = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (x >= r + bt) begin
				x = x - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	// 2^(30 - 2^-(b+1)) per fraction bit
	function automatic logic [FRAC_BITS-1:0][V_W-1:0] pow_table();
		logic [FRAC_BITS-1:0][V_W-1:0] tab;
		logic [63:0] c;
		c = isqrt64(64'd1 << 59);
		tab[0] = V_W'(c);
		for (int b = 1; b < FRAC_BITS; b++) begin
			c = isqrt64(c << 30);
			tab[b] = V_W'(c);
		end
		return tab;
	endfunction
endpackage

### rtl/mrst_exp.sv
`timescale 1ns / 1ps
module mrst_exp (
	input  logic               clk,
	input  logic               arst_n,
	input  mrst_pkg::exp_req_t req,
	output mrst_pkg::exp_rsp_t rsp
);
	import mrst_pkg::*;

	localparam logic [FRAC_BITS-1:0][V_W-1:0] POW_TAB = pow_table();

	exp_state_t state_q, state_d;
	logic [LOGIT_W-1:0] d_q;
	logic [T_W-1:0] t_q;
	logic [V_W-1:0] v_q;
	logic [BIT_IDX_W-1:0] b_q;
	logic [FRAC_BITS-1:0] frac;
	logic [6:0] n;
	logic [2*V_W-1:0] prod;
	logic [2*V_W:0] prod_rnd;
	logic [V_W-1:0] v_mul;
	logic [47:0] sc_tmp;
	logic [V_W-1:0] e_val;

	assign frac = t_q[T_W-8:T_W-7-FRAC_BITS];
	assign n = t_q[T_W-1:T_W-7];
	assign prod = v_q * POW_TAB[b_q];
	assign prod_rnd = {1'b0, prod} + ((2*V_W+1)'(1) << 29);
	assign v_mul = prod_rnd[V_W+29:30];

	always_comb begin
		sc_tmp = '0;
		if (n > 7'(N_MAX)) begin
			e_val = '0;
		end else if (n == 7'd0) begin
			e_val = v_q;
		end else begin
			sc_tmp = (48'(v_q) + (48'd1 << (n - 7'd1))) >> n;
			e_val = V_W'(sc_tmp);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			E_IDLE: begin
				if (req.start) state_d = E_MUL;
			end
			E_MUL: state_d = E_POW;
			E_POW: begin
				if (b_q == BIT_IDX_W'(FRAC_BITS - 1)) state_d = E_SCALE;
			end
			E_SCALE: state_d = E_IDLE;
			default: state_d = E_IDLE;
		endcase
	end

	always_comb begin
		rsp.done = (state_q == E_SCALE);
		rsp.e = e_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			b_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == E_MUL) b_q <= '0;
			else if (state_q == E_POW) b_q <= b_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && req.start) d_q <= req.diff;
		if (state_q == E_MUL) begin
			t_q <= d_q * LOG2E_Q15;
			v_q <= ONE_Q30;
		end
		if (state_q == E_POW && frac[BIT_IDX_W'(FRAC_BITS - 1) - b_q]) v_q <= v_mul;
	end
endmodule

### rtl/mrst_div.sv
`timescale 1ns / 1ps
module mrst_div #(
	parameter int SUMW = 35
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SUMW+16:0]    num,
	input  logic [SUMW-1:0]     den,
	output logic                done,
	output logic [16:0]         quo
);
	import mrst_pkg::*;

	div_state_t state_q, state_d;
	logic [SUMW-1:0] rem_q;
	logic [SUMW-1:0] den_q;
	logic [Q_STEPS-1:0] low_q;
	logic [4:0] cnt_q;
	logic [SUMW:0] trial;
	logic ge;

	assign trial = {rem_q, low_q[Q_STEPS-1]};
	assign ge = trial >= {1'b0, den_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			D_IDLE: begin
				if (start) state_d = D_RUN;
			end
			D_RUN: begin
				if (cnt_q == 5'(Q_STEPS - 1)) state_d = D_DONE;
			end
			D_DONE: state_d = D_IDLE;
			default: state_d = D_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == D_DONE);
		quo = low_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == D_IDLE) cnt_q <= '0;
			else if (state_q == D_RUN) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			rem_q <= num[SUMW+16:Q_STEPS];
			low_q <= num[Q_STEPS-1:0];
			den_q <= den;
		end else if (state_q == D_RUN) begin
			rem_q <= ge ? SUMW'(trial - {1'b0, den_q}) : SUMW'(trial);
			low_q <= {low_q[Q_STEPS-2:0], ge};
		end
	end
endmodule

### rtl/moe_router_softmax_topk.sv
// Router gate for a mixture-of-experts layer. Logit requests (signed Q5.10) are taken one per
// cycle, expert 0 first; each is placed into a sorted top list in the same cycle, lower expert
// index first on ties. The request flagged last_logit starts the gate pass, during which in_ready
// is low: for each of the m = min(experts, k_used) selected entries the shared exp unit does
// one 16x16 multiply, then one 31x31 multiply per fraction bit, and then for each entry the
// restoring divider produces one quotient bit per cycle before the result is offered.
// Results come highest first with a Q1.16 weight renormalized over the selection.
`timescale 1ns / 1ps
`include "moe_router_softmax_topk_macros.svh"
module moe_router_softmax_topk #(
	parameter int MAX_EXPERTS = 256,
	parameter int MAX_TOPK = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mrst_pkg::K_W-1:0]            cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [mrst_pkg::LOGIT_W-1:0] logit,
	input  logic                                last_logit,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mrst_pkg::ID_W-1:0]           expert_id,
	output logic [mrst_pkg::WGT_W-1:0]          gate_weight,
	output logic                                last_result
);
	import mrst_pkg::*;

	localparam int CW = $clog2(MAX_EXPERTS + 1);
	localparam int IW = (MAX_TOPK > 1) ? $clog2(MAX_TOPK) : 1;
	localparam int MW = $clog2(MAX_TOPK + 1);
	localparam int SUMW = V_W + $clog2(MAX_TOPK);

	ctl_state_t state_q, state_d;
	logic [K_W-1:0] k_q;
	logic [CW-1:0] count_q;
	logic signed [LOGIT_W-1:0] top_logit_q [MAX_TOPK];
	logic [ID_W-1:0] top_id_q [MAX_TOPK];
	logic [V_W-1:0] term_q [MAX_TOPK];
	logic [SUMW-1:0] sum_q;
	logic [IW-1:0] i_q;
	logic [MW-1:0] m_q;
	logic [ID_W-1:0] expert_id_q;
	logic [WGT_W-1:0] gate_weight_q;
	logic last_result_q;

	logic in_acc;
	logic room;
	logic [MAX_TOPK-1:0] put_new;
	logic [MAX_TOPK-1:0] shift_dn;
	logic found;
	logic [CW-1:0] count_after;
	logic [MW-1:0] k_clamp;
	logic [MW-1:0] m_next;
	logic at_last;
	exp_req_t exp_req;
	exp_rsp_t exp_rsp;
	logic div_start;
	logic div_done;
	logic [16:0] div_quo;

	assign in_acc = in_valid && in_ready;
	assign room = (32'(count_q) < MAX_EXPERTS);
	assign count_after = room ? count_q + 1'b1 : count_q;
	assign at_last = (MW'(i_q) + 1'b1 == m_q);

	always_comb begin
		found = 1'b0;
		put_new = '0;
		shift_dn = '0;
		for (int j = 0; j < MAX_TOPK; j++) begin
			if (found) begin
				shift_dn[j] = 1'b1;
			end else if (logit > top_logit_q[j] || 32'(count_q) == j) begin
				put_new[j] = 1'b1;
				found = 1'b1;
			end
		end
	end

	always_comb begin
		priority if (k_q == '0) begin
			k_clamp = MW'(1);
		end else if (32'(k_q) > MAX_TOPK) begin
			k_clamp = MW'(MAX_TOPK);
		end else begin
			k_clamp = MW'(k_q);
		end
		m_next = (32'(count_after) < 32'(k_clamp)) ? MW'(count_after) : k_clamp;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (in_acc && last_logit) state_d = S_EXP;
			end
			S_EXP: state_d = S_EXP_WAIT;
			S_EXP_WAIT: begin
				if (exp_rsp.done) state_d = at_last ? S_DIV : S_EXP;
			end
			S_DIV: state_d = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (div_done) state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) state_d = last_result_q ? S_LOAD : S_DIV;
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_comb begin
		in_ready = (state_q == S_LOAD);
		cfg_ready = 1'b1;
		out_valid = (state_q == S_OUT);
		exp_req.start = (state_q == S_EXP);
		exp_req.diff = LOGIT_W'(top_logit_q[0] - top_logit_q[i_q]);
		div_start = (state_q == S_DIV);
		expert_id = expert_id_q;
		gate_weight = gate_weight_q;
		last_result = last_result_q;
	end

	mrst_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (exp_req),
		.rsp    (exp_rsp)
	);

	mrst_div #(
		.SUMW(SUMW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ((SUMW + 17)'({term_q[i_q], 16'b0}) + (SUMW + 17)'(sum_q >> 1)),
		.den    (sum_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			k_q <= K_RESET;
			count_q <= '0;
			i_q <= '0;
			m_q <= '0;
			for (int j = 0; j < MAX_TOPK; j++) begin
				top_logit_q[j] <= LOGIT_MIN;
				top_id_q[j] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) k_q <= cfg_data;
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						count_q <= count_after;
						if (room) begin
							for (int j = 0; j < MAX_TOPK; j++) begin
								if (put_new[j]) begin
									top_logit_q[j] <= logit;
									top_id_q[j] <= ID_W'(count_q);
								end
							end
							for (int j = 1; j < MAX_TOPK; j++) begin
								if (shift_dn[j]) begin
									top_logit_q[j] <= top_logit_q[j-1];
									top_id_q[j] <= top_id_q[j-1];
								end
							end
						end
						if (last_logit) begin
							i_q <= '0;
							m_q <= m_next;
						end
					end
				end
				S_EXP_WAIT: begin
					if (exp_rsp.done) i_q <= at_last ? '0 : i_q + 1'b1;
				end
				S_OUT: begin
					if (out_ready) begin
						if (last_result_q) begin
							count_q <= '0;
							for (int j = 0; j < MAX_TOPK; j++) begin
								top_logit_q[j] <= LOGIT_MIN;
								top_id_q[j] <= '0;
							end
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && in_acc && last_logit) sum_q <= '0;
		if (state_q == S_EXP_WAIT && exp_rsp.done) begin
			term_q[i_q] <= exp_rsp.e;
			sum_q <= sum_q + SUMW'(exp_rsp.e);
		end
		if (state_q == S_DIV_WAIT && div_done) begin
			expert_id_q <= top_id_q[i_q];
			gate_weight_q <= div_quo;
			last_result_q <= at_last;
		end
	end

	`MRST_ASSERT_IMP(a_no_overlap, clk, arst_n, in_ready, !out_valid)
	`MRST_ASSERT_NXT(a_last_in_busy, clk, arst_n, in_valid && in_ready && last_logit, !in_ready)
	`MRST_ASSERT_NXT(a_last_out_free, clk, arst_n, out_valid && out_ready && last_result, in_ready)
endmodule

### tb/moe_router_softmax_topk_test.sv
`timescale 1ns / 1ps
module moe_router_softmax_topk_test;
	import mrst_pkg::*;

	localparam int NUM_EXPERTS = 256;
	localparam int TOPK_MAX = 16;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [ID_W-1:0] id;
		logic [WGT_W-1:0] weight;
		logic last;
	} gate_result_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [K_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [LOGIT_W-1:0] logit;
	logic last_logit;
	logic out_valid;
	logic out_ready;
	logic [ID_W-1:0] expert_id;
	logic [WGT_W-1:0] gate_weight;
	logic last_result;

	moe_router_softmax_topk u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.logit(logit),
		.last_logit(last_logit),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.expert_id(expert_id),
		.gate_weight(gate_weight),
		.last_result(last_result)
	);

	// predictor state
	logic [63:0] exp_coef[FRAC_BITS];
	logic [K_W-1:0] k_sel;
	int unsigned n_seen;
	int tok_max;
	int top_val[TOPK_MAX];
	int unsigned top_id[TOPK_MAX];
	gate_result_t gate_queue[$];

	int errors = 0;
	int unsigned cycles = 0;
	bit idle_on = 1;
	bit hold_sink = 0;

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] exp_of(int x);
		logic [63:0] d;
		logic [63:0] t;
		logic [63:0] n;
		logic [63:0] f;
		logic [63:0] v;
		d = 64'((tok_max - x) & 32'hFFFF);
		t = d * 64'd47274;
		n = t >> 25;
		f = (t >> 9) & 64'hFFFF;
		v = 64'd1 << 30;
		for (int b = 0; b < FRAC_BITS; b++)
			if (f[FRAC_BITS - 1 - b]) v = (v * exp_coef[b] + (64'd1 << 29)) >> 30;
		if (n > 40) return 0;
		if (n == 0) return v;
		return (v + (64'd1 << (n - 1))) >> n;
	endfunction

	task automatic clear_gate();
		n_seen = 0;
		tok_max = -32768;
		for (int i = 0; i < TOPK_MAX; i++) begin
			top_val[i] = -32768;
			top_id[i] = 0;
		end
	endtask

	task automatic predict_gate(logic signed [LOGIT_W-1:0] lg, logic lst);
		int x;
		int unsigned filled;
		int unsigned p;
		int unsigned j;
		int unsigned k;
		int unsigned m;
		logic [63:0] terms[TOPK_MAX];
		logic [63:0] sum;
		gate_result_t r;
		x = lg;
		if (n_seen < NUM_EXPERTS) begin
			if (x > tok_max) tok_max = x;
			filled = n_seen < TOPK_MAX ? n_seen : TOPK_MAX;
			p = filled;
			for (int i = 0; i < filled; i++)
				if (x > top_val[i]) begin
					p = i;
					break;
				end
			if (p < TOPK_MAX) begin
				j = filled < TOPK_MAX ? filled : TOPK_MAX - 1;
				while (j > p) begin
					top_val[j] = top_val[j - 1];
					top_id[j] = top_id[j - 1];
					j--;
				end
				top_val[p] = x;
				top_id[p] = n_seen;
			end
			n_seen++;
		end
		if (!lst) return;
		k = k_sel;
		if (k < 1) k = 1;
		if (k > TOPK_MAX) k = TOPK_MAX;
		m = n_seen < k ? n_seen : k;
		sum = 0;
		for (int i = 0; i < m; i++) begin
			terms[i] = exp_of(top_val[i]);
			sum += terms[i];
		end
		for (int i = 0; i < m; i++) begin
			r.id = ID_W'(top_id[i]);
			r.weight = WGT_W'(((terms[i] << 16) + (sum >> 1)) / sum);
			r.last = (i + 1 == m);
			gate_queue.push_back(r);
		end
		clear_gate();
	endtask

	task automatic report(string what, int unsigned got, int unsigned want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("moe_router_softmax_topk_test: FAIL");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		gate_result_t w;
		if (arst_n && out_valid && out_ready) begin
			if (gate_queue.size() == 0) begin
				report("unexpected result", expert_id, 0);
			end else begin
				w = gate_queue.pop_front();
				if (expert_id !== w.id) report("expert_id", expert_id, w.id);
				if (gate_weight !== w.weight) report("gate_weight", gate_weight, w.weight);
				if (last_result !== w.last) report("last_result", last_result, w.last);
			end
		end
	end

	// result sink with random stalls
	initial begin
		int n;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				out_ready <= 0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 13);
				out_ready <= 0;
				repeat (n) @(negedge clk);
				out_ready <= 1;
			end else begin
				out_ready <= 1;
			end
		end
	end

	task automatic send_logit(logic signed [LOGIT_W-1:0] lg, logic lst);
		if (idle_on && $urandom_range(0, 6) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_valid <= 1;
		logit <= lg;
		last_logit <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_gate(lg, lst);
		@(negedge clk);
		if (lst) begin
			in_valid <= 0;
			@(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (gate_queue.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_k(logic [K_W-1:0] v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		k_sel = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic logic signed [LOGIT_W-1:0] rand_logit();
		case ($urandom_range(0, 3))
			0: return LOGIT_W'($urandom);
			1: return LOGIT_W'($urandom_range(0, 4095) - 2048);
			2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return LOGIT_W'($urandom_range(0, 255) * 16);
		endcase
	endfunction

	task automatic send_token(int n);
		for (int i = 0; i < n; i++) send_logit(rand_logit(), i == n - 1);
	endtask

	task automatic test_extremes();
		write_k(5'd16);
		send_logit(16'sh7fff, 0);
		send_logit(16'sh8000, 0);
		send_logit(16'sh0000, 0);
		send_logit(16'sh7fff, 1);
		send_logit(16'sh8000, 1);
		for (int i = 0; i < 6; i++) send_logit(16'sh0100, i == 5);
		write_k(5'd0);
		send_logit(16'sh0400, 0);
		send_logit(16'sh0800, 1);
		write_k(5'd31);
		send_token(17);
	endtask

	task automatic test_surplus();
		write_k(5'd3);
		for (int i = 0; i < 258; i++) send_logit(i == 256 ? 16'sh7fff : rand_logit(), i == 257);
	endtask

	task automatic test_k_change();
		send_logit(16'sh0200, 0);
		send_logit(16'sh0300, 0);
		write_k(5'd1);
		send_logit(16'sh0100, 1);
	endtask

	task automatic test_backpressure();
		write_k(5'd16);
		fork
			begin
				hold_sink = 1;
				repeat (400) @(negedge clk);
				hold_sink = 0;
			end
			repeat (2) send_token(17);
		join
		drain();
	endtask

	task automatic test_random();
		int sent;
		sent = 0;
		while (sent < 20) begin
			int n;
			if ($urandom_range(0, 7) == 0) write_k(K_W'($urandom_range(0, 31)));
			n = $urandom_range(1, 20);
			send_token(n);
			sent += n;
			if (sent > 10) idle_on = 0;
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_valid = 0;
		cfg_data = 0;
		in_valid = 0;
		logit = 0;
		last_logit = 0;
		exp_coef[0] = int_sqrt(64'd1 << 59);
		for (int b = 1; b < FRAC_BITS; b++) exp_coef[b] = int_sqrt(exp_coef[b - 1] << 30);
		k_sel = K_RESET;
		clear_gate();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		send_token(10);
		test_extremes();
		test_surplus();
		test_k_change();
		test_backpressure();
		test_random();
		drain();
		if (errors == 0) $display("moe_router_softmax_topk_test: PASS");
		else $display("moe_router_softmax_topk_test: FAIL");
		$finish;
	end
endmodule
